### src/sgp_pkg.sv
// shared types and constants for the serial gamepad frame parser
package sgp_pkg;

   // header bytes
   localparam logic [7:0] HDR_M = 8'h6D;
   localparam logic [7:0] HDR_B = 8'h62;
   localparam logic [7:0] HDR_A = 8'h61;
   localparam logic [7:0] HDR_O = 8'h6F;

   // flips the sign bit, i.e. subtracts 32768 mod 2^16
   localparam logic [15:0] AXIS_OFFSET = 16'h8000;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned AXIS_W   = 16;
   localparam int unsigned REPORT_W = 4 * BYTE_W + 4 * AXIS_W;

   // frame position; codes 12 to 15 are unreachable
   typedef enum logic [3:0] {
      POS_HDR0     = 4'd0,
      POS_HDR1     = 4'd1,
      POS_BTN_A    = 4'd2,
      POS_BTN_B    = 4'd3,
      POS_TRIG_L   = 4'd4,
      POS_TRIG_R   = 4'd5,
      POS_LX       = 4'd6,
      POS_LY       = 4'd7,
      POS_RX_LO    = 4'd8,
      POS_RX_HI    = 4'd9,
      POS_RY_LO    = 4'd10,
      POS_RY_HI    = 4'd11
   } frame_pos_type;

endpackage

### src/serial_gamepad_frame_parser_unit.sv
// serial gamepad frame parser: byte stream in, full pad report out per byte
//
// Every accepted request byte yields exactly one report. A byte passes an input
// register, then decode updates the held report, which is itself the output
// register. Throughput is one byte per clock while the receiver keeps rsp_tready
// high. While a finished report waits on rsp_tready the input register still
// takes one byte if it is empty; once both registers hold data, req_tready
// follows rsp_tready in the same cycle, so a stall passes straight back to the
// sender and adds no bubble after it clears.
// A frame is a two-byte header ('m' or 'b', then 'a') and ten payload
// bytes: two button bytes, two triggers (doubled), left stick X/Y as
// (byte-128)*256, right stick X/Y as little-endian words minus 32768. While a
// right stick word is half received, its field shows the raw low byte. An 'o'
// in place of the 'a' flags a boot request on that one report (rsp_tuser) and
// restarts header search.
module serial_gamepad_frame_parser_unit
   import sgp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] rx_byte
   // report channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [7:0] buttons_a, [15:8] buttons_b, [23:16] left_trigger,
   // [31:24] right_trigger, [47:32] left_x, [63:48] left_y,
   // [79:64] right_x, [95:80] right_y
   output logic [REPORT_W-1:0] rsp_tdata,
   output logic                rsp_tuser    // [0] boot_request
);

   // input register
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;

   // decode stage fires when the output register is free or being drained
   logic             advance;
   logic             fire;

   // frame position and held report
   frame_pos_type    pos_ff, pos_in;
   logic [7:0]       btn_a_ff, btn_a_in;
   logic [7:0]       btn_b_ff, btn_b_in;
   logic [7:0]       trig_l_ff, trig_l_in;
   logic [7:0]       trig_r_ff, trig_r_in;
   logic [15:0]      lx_ff, lx_in;
   logic [15:0]      ly_ff, ly_in;
   logic [15:0]      rx_ff, rx_in;
   logic [15:0]      ry_ff, ry_in;
   logic             boot_ff, boot_in;
   logic             out_valid_ff, out_valid_in;

   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && !rsp_tready);

   // next frame position
   always_comb begin
      unique case (pos_ff)
         POS_HDR0:   pos_in = (in_byte_ff == HDR_M || in_byte_ff == HDR_B) ? POS_HDR1
                                                                         : POS_HDR0;
         POS_HDR1:   pos_in = (in_byte_ff == HDR_A) ? POS_BTN_A : POS_HDR0;
         POS_BTN_A:  pos_in = POS_BTN_B;
         POS_BTN_B:  pos_in = POS_TRIG_L;
         POS_TRIG_L: pos_in = POS_TRIG_R;
         POS_TRIG_R: pos_in = POS_LX;
         POS_LX:     pos_in = POS_LY;
         POS_LY:     pos_in = POS_RX_LO;
         POS_RX_LO:  pos_in = POS_RX_HI;
         POS_RX_HI:  pos_in = POS_RY_LO;
         POS_RY_LO:  pos_in = POS_RY_HI;
         POS_RY_HI:  pos_in = POS_HDR0;
         default:    pos_in = POS_HDR0;   // unused codes resync
      endcase
   end

   // report field updates
   always_comb begin
      btn_a_in  = btn_a_ff;
      btn_b_in  = btn_b_ff;
      trig_l_in = trig_l_ff;
      trig_r_in = trig_r_ff;
      lx_in     = lx_ff;
      ly_in     = ly_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      boot_in   = 1'b0;
      unique case (pos_ff)
         POS_HDR0:   ;
         POS_HDR1:   boot_in   = (in_byte_ff == HDR_O);
         POS_BTN_A:  btn_a_in  = in_byte_ff;
         POS_BTN_B:  btn_b_in  = in_byte_ff;
         POS_TRIG_L: trig_l_in = {in_byte_ff[6:0], 1'b0};
         POS_TRIG_R: trig_r_in = {in_byte_ff[6:0], 1'b0};
         POS_LX:     lx_in     = {in_byte_ff, 8'h00} ^ AXIS_OFFSET;
         POS_LY:     ly_in     = {in_byte_ff, 8'h00} ^ AXIS_OFFSET;
         POS_RX_LO:  rx_in     = {8'h00, in_byte_ff};
         POS_RX_HI:  rx_in     = ({in_byte_ff, 8'h00} | rx_ff) ^ AXIS_OFFSET;
         POS_RY_LO:  ry_in     = {8'h00, in_byte_ff};
         POS_RY_HI:  ry_in     = ({in_byte_ff, 8'h00} | ry_ff) ^ AXIS_OFFSET;
         default:    ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= POS_HDR0;
         btn_a_ff     <= '0;
         btn_b_ff     <= '0;
         trig_l_ff    <= '0;
         trig_r_ff    <= '0;
         lx_ff        <= '0;
         ly_ff        <= '0;
         rx_ff        <= '0;
         ry_ff        <= '0;
         boot_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            pos_ff    <= pos_in;
            btn_a_ff  <= btn_a_in;
            btn_b_ff  <= btn_b_in;
            trig_l_ff <= trig_l_in;
            trig_r_ff <= trig_r_in;
            lx_ff     <= lx_in;
            ly_ff     <= ly_in;
            rx_ff     <= rx_in;
            ry_ff     <= ry_in;
            boot_ff   <= boot_in;
         end
      end
   end

   // input byte register, loaded on each accepted request
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // the held report is the output register
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {ry_ff, rx_ff, ly_ff, lx_ff, trig_r_ff, trig_l_ff, btn_b_ff, btn_a_ff};
   assign rsp_tuser  = boot_ff;

endmodule

### src/sgp_checker.sv
// port-level checks for the serial gamepad frame parser, bound to the top level
module sgp_checker
   import sgp_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [REPORT_W-1:0] rsp_tdata,
   input logic                rsp_tuser
);

   // pipeline empties on reset and is ready for a request
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("pipeline not empty after reset");

   // a stalled report holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled report changed");

   // doubled triggers are always even
   a_trig_even: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[16] == 1'b0 && rsp_tdata[24] == 1'b0))
      else $error("trigger field odd");

   // a boot report restarts header search, so the next report cannot flag boot
   a_boot_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tuser) |=> !(rsp_tvalid && rsp_tuser))
      else $error("boot request on consecutive reports");

   // a boot report leaves the report fields as they were
   a_boot_no_change: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_tuser) && rsp_tvalid && $past(rsp_tvalid) && !$past(reset))
         |-> $stable(rsp_tdata))
      else $error("boot report altered fields");

endmodule

bind serial_gamepad_frame_parser_unit sgp_checker u_sgp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/serial_gamepad_frame_parser_unit_tb.sv
// self-checking testbench for the serial gamepad frame parser unit
`timescale 1ns / 100ps

module serial_gamepad_frame_parser_unit_tb;
   import sgp_pkg::*;

   localparam int CLK_PERIOD  = 8;
   localparam int RANDOM_REQS = 1250;
   localparam int TAIL_REQS   = 150;     // no idling once this few requests remain
   localparam int LONG_HOLD   = 200;     // one long receiver stall, in cycles
   localparam int HOLD_AT     = 300;     // reports seen before the long stall
   localparam int DRAIN_WAIT  = 8;
   localparam int LIMIT_CYCLES = 200000;
   localparam int REPORT_LIMIT = 10;

   // report as the block emits it, boot flag on top of rsp_tdata
   typedef struct packed {
      logic               boot;
      logic signed [15:0] right_y;
      logic signed [15:0] right_x;
      logic signed [15:0] left_y;
      logic signed [15:0] left_x;
      logic [7:0]         right_trigger;
      logic [7:0]         left_trigger;
      logic [7:0]         buttons_b;
      logic [7:0]         buttons_a;
   } pad_report_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata = 8'h00;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [REPORT_W-1:0] rsp_tdata;
   logic                rsp_tuser;

   // parser shadow state
   frame_pos_type  frame_pos;
   pad_report_type held_report;

   logic [7:0]     outgoing_bytes[$];
   pad_report_type expected_reports[$];
   int             requests_total;
   int             requests_accepted;
   int             reports_checked;
   int             mismatches;
   int             send_idle_left;
   int             recv_stall_left;
   bit             long_hold_done;
   int             cycle_count;
   pad_report_type seen_report;

   serial_gamepad_frame_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // advances the shadow parser by one byte and returns the report it emits
   function automatic pad_report_type advance_pad_report(input logic [7:0] rx);
      pad_report_type rep;
      frame_pos_type  nxt;
      nxt = frame_pos_type'(frame_pos + 4'd1);
      rep = '0;
      case (frame_pos)
         POS_HDR0: begin
            nxt = (rx == HDR_M || rx == HDR_B) ? POS_HDR1 : POS_HDR0;
         end
         POS_HDR1: begin
            rep.boot = (rx == HDR_O);
            nxt = (rx == HDR_A) ? POS_BTN_A : POS_HDR0;
         end
         POS_BTN_A:  held_report.buttons_a = rx;
         POS_BTN_B:  held_report.buttons_b = rx;
         POS_TRIG_L: held_report.left_trigger = {rx[6:0], 1'b0};
         POS_TRIG_R: held_report.right_trigger = {rx[6:0], 1'b0};
         POS_LX:     held_report.left_x = {rx, 8'h00} - AXIS_OFFSET;
         POS_LY:     held_report.left_y = {rx, 8'h00} - AXIS_OFFSET;
         // low byte sits raw until its high byte completes the word
         POS_RX_LO:  held_report.right_x = {8'h00, rx};
         POS_RX_HI:  held_report.right_x = ({rx, 8'h00} | held_report.right_x) - AXIS_OFFSET;
         POS_RY_LO:  held_report.right_y = {8'h00, rx};
         POS_RY_HI: begin
            held_report.right_y = ({rx, 8'h00} | held_report.right_y) - AXIS_OFFSET;
            nxt = POS_HDR0;
         end
         default: nxt = POS_HDR0;
      endcase
      frame_pos = nxt;
      rep.buttons_a     = held_report.buttons_a;
      rep.buttons_b     = held_report.buttons_b;
      rep.left_trigger  = held_report.left_trigger;
      rep.right_trigger = held_report.right_trigger;
      rep.left_x        = held_report.left_x;
      rep.left_y        = held_report.left_y;
      rep.right_x       = held_report.right_x;
      rep.right_y       = held_report.right_y;
      return rep;
   endfunction

   function automatic bit reports_differ(input pad_report_type a, input pad_report_type b);
      return a.buttons_a != b.buttons_a || a.buttons_b != b.buttons_b
         || a.left_trigger != b.left_trigger || a.right_trigger != b.right_trigger
         || a.left_x != b.left_x || a.left_y != b.left_y
         || a.right_x != b.right_x || a.right_y != b.right_y || a.boot != b.boot;
   endfunction

   function automatic string report_text(input pad_report_type r);
      return $sformatf("btn=%02h/%02h trig=%02h/%02h l=%0d/%0d r=%0d/%0d boot=%0b",
         r.buttons_a, r.buttons_b, r.left_trigger, r.right_trigger,
         r.left_x, r.left_y, r.right_x, r.right_y, r.boot);
   endfunction

   task automatic log_mismatch(input string what, input pad_report_type want,
                               input pad_report_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch, %s, report %0d: expected %s, actual %s", what,
            reports_checked, report_text(want), report_text(got));
   endtask

   function automatic logic [7:0] payload_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] header_byte();
      return $urandom_range(0, 1) ? HDR_M : HDR_B;
   endfunction

   // request driver: offers queued bytes, predicts on each accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'h00;
         send_idle_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_reports.push_back(advance_pad_report(req_tdata));
            requests_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_idle_left > 0) begin
               send_idle_left--;
               req_tvalid <= 1'b0;
            end else if (outgoing_bytes.size() > 0) begin
               req_tdata <= outgoing_bytes.pop_front();
               req_tvalid <= 1'b1;
               if (outgoing_bytes.size() >= TAIL_REQS && $urandom_range(0, 5) == 0)
                  send_idle_left = $urandom_range(1, 9);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // report receiver: random stall bursts plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall_left = 0;
      end else if (recv_stall_left > 0) begin
         recv_stall_left--;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && reports_checked >= HOLD_AT) begin
         long_hold_done = 1'b1;
         recv_stall_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (outgoing_bytes.size() >= TAIL_REQS && $urandom_range(0, 4) == 0) begin
         recv_stall_left = $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // report monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_report = pad_report_type'({rsp_tuser, rsp_tdata});
         reports_checked++;
         if (expected_reports.size() == 0)
            log_mismatch("unexpected", '0, seen_report);
         else if (reports_differ(expected_reports[0], seen_report))
            log_mismatch("wrong field", expected_reports[0], seen_report);
         if (expected_reports.size() > 0)
            void'(expected_reports.pop_front());
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [7:0] directed[29];
      int         random_reqs;
      int         n;
      frame_pos = POS_HDR0;
      held_report = '0;

      // full-scale frame, a bad first header byte, a bad second header byte,
      // a boot request, then a frame at mid-scale and the other extremes
      directed = '{HDR_M, HDR_A, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF,
                   8'hFF, 8'hFF, 8'h00, 8'h00,
                   8'h00, HDR_B, HDR_B, HDR_M, HDR_O,
                   HDR_B, HDR_A, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h80, 8'h7F,
                   8'h00, 8'h80, 8'hFF, 8'h7F};
      foreach (directed[i])
         outgoing_bytes.push_back(directed[i]);

      // mostly well-formed frames with random content, interleaved at random with broken
      // headers, boot requests, truncated frames and line noise
      random_reqs = 0;
      while (random_reqs < RANDOM_REQS) begin
         case ($urandom_range(0, 19))
            14, 15: begin
               outgoing_bytes.push_back(header_byte());
               outgoing_bytes.push_back(8'($urandom_range(0, 255)));
               random_reqs += 2;
            end
            16: begin
               outgoing_bytes.push_back(header_byte());
               outgoing_bytes.push_back(HDR_O);
               random_reqs += 2;
            end
            17: begin
               n = $urandom_range(0, 9);
               outgoing_bytes.push_back(header_byte());
               outgoing_bytes.push_back(HDR_A);
               repeat (n) outgoing_bytes.push_back(payload_byte());
               random_reqs += 2 + n;
            end
            18, 19: begin
               n = $urandom_range(1, 6);
               repeat (n) outgoing_bytes.push_back(8'($urandom_range(0, 255)));
               random_reqs += n;
            end
            default: begin
               outgoing_bytes.push_back(header_byte());
               outgoing_bytes.push_back(HDR_A);
               repeat (10) outgoing_bytes.push_back(payload_byte());
               random_reqs += 12;
            end
         endcase
      end
      requests_total = outgoing_bytes.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (requests_accepted < requests_total) @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0 && expected_reports.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
